[rtl/projective_point_map_defines.svh]
// ----------------------------------------------------------------------------
// projective_point_map assertion macros
// shared property forms for the point map assertions
// ----------------------------------------------------------------------------
`ifndef PROJECTIVE_POINT_MAP_DEFINES_SVH
`define PROJECTIVE_POINT_MAP_DEFINES_SVH

// same-cycle implication
`define PPM_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define PPM_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[rtl/ppm_pkg.sv]
// ----------------------------------------------------------------------------
// ppm_pkg
// shared types and constants of the projective point map
// ----------------------------------------------------------------------------
package ppm_pkg;

   localparam int COEF_W    = 48;
   localparam int INDEX_W   = 4;
   localparam int NUM_COEFS = 9;
   localparam int STATUS_W  = 2;

   // map status codes
   localparam logic [STATUS_W-1:0] STATUS_OK   = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_ZERO = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_SAT  = 2'd2;

   typedef enum logic {
      REQ_LOAD = 1'b0,
      REQ_MAP  = 1'b1
   } ppm_kind_type;

   // head of the front queue as seen by the back end
   typedef struct packed {
      logic                 valid;
      ppm_kind_type         kind;
      logic [INDEX_W-1:0]   index;
   } ppm_ctrl_type;

endpackage

[rtl/ppm_front.sv]
// ----------------------------------------------------------------------------
// ppm_front
// accepts request transactions, drops out-of-range loads, queues the rest
// ----------------------------------------------------------------------------
module ppm_front
   import ppm_pkg::*;
#(
   parameter int COORD_BITS = 16
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic                         req_type,
   input  logic [INDEX_W-1:0]           req_coef_index,
   input  logic signed [COEF_W-1:0]     req_coef_value,
   input  logic signed [COORD_BITS-1:0] req_in_x,
   input  logic signed [COORD_BITS-1:0] req_in_y,
   input  logic                         adv,
   output ppm_ctrl_type                 q_ctrl,
   output logic signed [COEF_W-1:0]     q_value,
   output logic signed [COORD_BITS-1:0] q_x,
   output logic signed [COORD_BITS-1:0] q_y
);

   localparam int QDEPTH = 4;
   localparam int PTR_W  = $clog2(QDEPTH);
   localparam int CNT_W  = $clog2(QDEPTH + 1);

   ppm_kind_type                 kind_mem  [QDEPTH];
   logic [INDEX_W-1:0]           index_mem [QDEPTH];
   logic signed [COEF_W-1:0]     value_mem [QDEPTH];
   logic signed [COORD_BITS-1:0] x_mem     [QDEPTH];
   logic signed [COORD_BITS-1:0] y_mem     [QDEPTH];

   logic [PTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [CNT_W-1:0] count_ff;
   logic             accept, keep, push, pop;

   assign req_stall = (count_ff == CNT_W'(QDEPTH));
   assign accept    = req_valid && !req_stall;
   // loads beyond the matrix are swallowed here
   assign keep      = (ppm_kind_type'(req_type) == REQ_MAP)
                      || (req_coef_index < INDEX_W'(NUM_COEFS));
   assign push      = accept && keep;
   assign pop       = adv && (count_ff != '0);

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + PTR_W'(1);
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + PTR_W'(1);
         end
         if (push && !pop) begin
            count_ff <= count_ff + CNT_W'(1);
         end else if (pop && !push) begin
            count_ff <= count_ff - CNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         kind_mem[wr_ptr_ff]  <= ppm_kind_type'(req_type);
         index_mem[wr_ptr_ff] <= req_coef_index;
         value_mem[wr_ptr_ff] <= req_coef_value;
         x_mem[wr_ptr_ff]     <= req_in_x;
         y_mem[wr_ptr_ff]     <= req_in_y;
      end
   end

   assign q_ctrl.valid = (count_ff != '0);
   assign q_ctrl.kind  = kind_mem[rd_ptr_ff];
   assign q_ctrl.index = index_mem[rd_ptr_ff];
   assign q_value      = value_mem[rd_ptr_ff];
   assign q_x          = x_mem[rd_ptr_ff];
   assign q_y          = y_mem[rd_ptr_ff];

endmodule

[rtl/ppm_div.sv]
// ----------------------------------------------------------------------------
// ppm_div
// pipelined restoring divider, one quotient bit per stage, saturating output
// ----------------------------------------------------------------------------
module ppm_div
   import ppm_pkg::*;
#(
   parameter int COORD_BITS = 16,
   parameter int NUMW       = 68,
   parameter int DENW       = 67
) (
   input  logic                         clock,
   input  logic                         en,
   input  logic [NUMW-1:0]              num,
   input  logic [DENW-1:0]              den,
   input  logic                         neg,
   output logic signed [COORD_BITS-1:0] value,
   output logic                         sat
);

   localparam int CW = NUMW + COORD_BITS;

   logic [CW-1:0]         rem_ff [COORD_BITS+1];
   logic [DENW-1:0]       den_ff [COORD_BITS+1];
   logic [COORD_BITS-1:0] q_ff   [COORD_BITS+1];
   logic                  neg_ff [COORD_BITS+1];
   logic                  ovf_ff [COORD_BITS+1];

   logic [COORD_BITS-1:0] lim, mag;
   logic                  sat_in;

   // quotient beyond its bit width saturates anyway
   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff[0] <= CW'(num);
         den_ff[0] <= den;
         q_ff[0]   <= '0;
         neg_ff[0] <= neg;
         ovf_ff[0] <= CW'(num) >= (CW'(den) << COORD_BITS);
      end
   end

   for (genvar t = 1; t <= COORD_BITS; t++) begin : g_stage
      localparam int B = COORD_BITS - t;
      logic [CW-1:0] shifted;
      logic          fits;
      assign shifted = CW'(den_ff[t-1]) << B;
      assign fits    = rem_ff[t-1] >= shifted;
      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[t] <= fits ? rem_ff[t-1] - shifted : rem_ff[t-1];
            q_ff[t]   <= fits ? (q_ff[t-1] | (COORD_BITS'(1) << B)) : q_ff[t-1];
            den_ff[t] <= den_ff[t-1];
            neg_ff[t] <= neg_ff[t-1];
            ovf_ff[t] <= ovf_ff[t-1];
         end
      end
   end

   always_comb begin
      lim    = neg_ff[COORD_BITS] ? {1'b1, {(COORD_BITS-1){1'b0}}}
                                  : {1'b0, {(COORD_BITS-1){1'b1}}};
      sat_in = ovf_ff[COORD_BITS] || (q_ff[COORD_BITS] > lim);
      mag    = sat_in ? lim : q_ff[COORD_BITS];
   end

   always_ff @(posedge clock) begin
      if (en) begin
         value <= neg_ff[COORD_BITS] ? -mag : mag;
         sat   <= sat_in;
      end
   end

endmodule

[rtl/ppm_back.sv]
// ----------------------------------------------------------------------------
// ppm_back
// coefficient store, row products and sums, two dividers and result register
// ----------------------------------------------------------------------------
`include "projective_point_map_defines.svh"

module ppm_back
   import ppm_pkg::*;
#(
   parameter int COORD_BITS = 16
) (
   input  logic                         clock,
   input  logic                         reset,
   input  ppm_ctrl_type                 q_ctrl,
   input  logic signed [COEF_W-1:0]     q_value,
   input  logic signed [COORD_BITS-1:0] q_x,
   input  logic signed [COORD_BITS-1:0] q_y,
   output logic                         adv,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic signed [COORD_BITS-1:0] rsp_out_x,
   output logic signed [COORD_BITS-1:0] rsp_out_y,
   output logic [STATUS_W-1:0]          rsp_map_status
);

   localparam int PW   = COEF_W + COORD_BITS;
   localparam int SW   = PW + 2;
   localparam int NUMW = SW + 2;
   localparam int DENW = SW + 1;
   localparam int DL   = COORD_BITS + 2;

   logic signed [COEF_W-1:0] coef_ff [NUM_COEFS];

   logic signed [PW-1:0]     prod_ff [6];
   logic signed [COEF_W-1:0] cst_ff  [3];
   logic signed [SW-1:0]     sx_ff, sy_ff, sw_ff;
   logic [SW-1:0]            ax_ff, ay_ff, aw_ff;
   logic                     negx_ff, negy_ff, zero3_ff;
   logic [NUMW-1:0]          numx_ff, numy_ff;
   logic [DENW-1:0]          den_ff;
   logic                     negx4_ff, negy4_ff, zero4_ff;
   logic                     v1_ff, v2_ff, v3_ff, v4_ff;
   logic [DL-1:0]            vd_ff, zd_ff;

   logic signed [COORD_BITS-1:0] divx, divy;
   logic                         satx, saty;
   logic                         take;

   logic                         rsp_valid_ff;
   logic signed [COORD_BITS-1:0] rsp_x_ff, rsp_y_ff;
   logic [STATUS_W-1:0]          rsp_status_ff;

   assign adv  = !rsp_valid_ff || !rsp_stall;
   assign take = adv && q_ctrl.valid;

   always_ff @(posedge clock) begin
      if (take && (q_ctrl.kind == REQ_LOAD)) begin
         coef_ff[q_ctrl.index] <= q_value;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         prod_ff[0] <= coef_ff[0] * q_x;
         prod_ff[1] <= coef_ff[1] * q_y;
         prod_ff[2] <= coef_ff[3] * q_x;
         prod_ff[3] <= coef_ff[4] * q_y;
         prod_ff[4] <= coef_ff[6] * q_x;
         prod_ff[5] <= coef_ff[7] * q_y;
         cst_ff[0]  <= coef_ff[2];
         cst_ff[1]  <= coef_ff[5];
         cst_ff[2]  <= coef_ff[8];

         sx_ff <= SW'(prod_ff[0]) + SW'(prod_ff[1]) + SW'(cst_ff[0]);
         sy_ff <= SW'(prod_ff[2]) + SW'(prod_ff[3]) + SW'(cst_ff[1]);
         sw_ff <= SW'(prod_ff[4]) + SW'(prod_ff[5]) + SW'(cst_ff[2]);

         ax_ff    <= sx_ff[SW-1] ? -sx_ff : sx_ff;
         ay_ff    <= sy_ff[SW-1] ? -sy_ff : sy_ff;
         aw_ff    <= sw_ff[SW-1] ? -sw_ff : sw_ff;
         negx_ff  <= sx_ff[SW-1] ^ sw_ff[SW-1];
         negy_ff  <= sy_ff[SW-1] ^ sw_ff[SW-1];
         zero3_ff <= (sw_ff == '0);

         // rounding half away: (2|n| + |w|) / (2|w|)
         numx_ff  <= {1'b0, ax_ff, 1'b0} + NUMW'(aw_ff);
         numy_ff  <= {1'b0, ay_ff, 1'b0} + NUMW'(aw_ff);
         den_ff   <= {aw_ff, 1'b0};
         negx4_ff <= negx_ff;
         negy4_ff <= negy_ff;
         zero4_ff <= zero3_ff;

         zd_ff <= {zd_ff[DL-2:0], zero4_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         vd_ff <= '0;
      end else if (adv) begin
         v1_ff <= take && (q_ctrl.kind == REQ_MAP);
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
         vd_ff <= {vd_ff[DL-2:0], v4_ff};
      end
   end

   ppm_div #(
      .COORD_BITS (COORD_BITS),
      .NUMW       (NUMW),
      .DENW       (DENW)
   ) u_div_x (
      .clock (clock),
      .en    (adv),
      .num   (numx_ff),
      .den   (den_ff),
      .neg   (negx4_ff),
      .value (divx),
      .sat   (satx)
   );

   ppm_div #(
      .COORD_BITS (COORD_BITS),
      .NUMW       (NUMW),
      .DENW       (DENW)
   ) u_div_y (
      .clock (clock),
      .en    (adv),
      .num   (numy_ff),
      .den   (den_ff),
      .neg   (negy4_ff),
      .value (divy),
      .sat   (saty)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= vd_ff[DL-1];
      end
   end

   always_ff @(posedge clock) begin
      if (adv && vd_ff[DL-1]) begin
         if (zd_ff[DL-1]) begin
            rsp_x_ff      <= '0;
            rsp_y_ff      <= '0;
            rsp_status_ff <= STATUS_ZERO;
         end else begin
            rsp_x_ff      <= divx;
            rsp_y_ff      <= divy;
            rsp_status_ff <= (satx || saty) ? STATUS_SAT : STATUS_OK;
         end
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_out_x      = rsp_x_ff;
   assign rsp_out_y      = rsp_y_ff;
   assign rsp_map_status = rsp_status_ff;

   `PPM_ASSERT_IMPLY(a_zero_scale_out, clock, reset, rsp_valid_ff && rsp_status_ff == STATUS_ZERO, rsp_x_ff == '0 && rsp_y_ff == '0, "zero scale result with nonzero coordinates")
   `PPM_ASSERT_IMPLY(a_status_code, clock, reset, rsp_valid_ff, rsp_status_ff == STATUS_OK || rsp_status_ff == STATUS_ZERO || rsp_status_ff == STATUS_SAT, "undefined status code")
   `PPM_ASSERT_NEXT(a_load_no_result, clock, reset, take && q_ctrl.kind == REQ_LOAD, !v1_ff, "load entered the map pipeline")

endmodule

[rtl/projective_point_map.sv]
// ----------------------------------------------------------------------------
// projective_point_map
// maps integer points through a stored 3x3 homography with rounding and saturation
// ----------------------------------------------------------------------------
// The block accepts one transaction per cycle on the request channel and
// returns one mapped point per cycle on the response channel as long as the
// response side does not stall. A load transaction (req_type 0) writes one
// row-major coefficient and returns nothing; loads with an index above 8 are
// dropped. A map transaction (req_type 1) returns x and y of the projected
// point, rounded half away from zero and saturated, with map_status 0 ok,
// 1 zero homogeneous scale (coordinates forced to zero) or 2 saturated.
// A response passes the four-entry front queue, four arithmetic stages
// (products, row sums, magnitudes, rounding offset), the divider pipeline
// that resolves one quotient bit per stage and the result register. Loads
// take effect in order with maps, so a point always sees the matrix as
// loaded before it.
// Coefficients must be loaded before a map uses them.
// ----------------------------------------------------------------------------
module projective_point_map
   import ppm_pkg::*;
#(
   parameter int COORD_BITS = 16
) (
   input  logic                         clock,
   input  logic                         reset,
   // request channel
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic                         req_type,
   input  logic [INDEX_W-1:0]           req_coef_index,
   input  logic signed [COEF_W-1:0]     req_coef_value,
   input  logic signed [COORD_BITS-1:0] req_in_x,
   input  logic signed [COORD_BITS-1:0] req_in_y,
   // response channel
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic signed [COORD_BITS-1:0] rsp_out_x,
   output logic signed [COORD_BITS-1:0] rsp_out_y,
   output logic [STATUS_W-1:0]          rsp_map_status
);

   // head of the front queue and the back end's advance strobe
   ppm_ctrl_type                 q_ctrl;
   logic signed [COEF_W-1:0]     q_value;
   logic signed [COORD_BITS-1:0] q_x, q_y;
   logic                         adv;

   // front: takes transactions, filters bad loads, buffers them
   ppm_front #(
      .COORD_BITS (COORD_BITS)
   ) u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_type       (req_type),
      .req_coef_index (req_coef_index),
      .req_coef_value (req_coef_value),
      .req_in_x       (req_in_x),
      .req_in_y       (req_in_y),
      .adv            (adv),
      .q_ctrl         (q_ctrl),
      .q_value        (q_value),
      .q_x            (q_x),
      .q_y            (q_y)
   );

   // back: matrix store and the arithmetic pipeline, stalls as one unit
   ppm_back #(
      .COORD_BITS (COORD_BITS)
   ) u_back (
      .clock          (clock),
      .reset          (reset),
      .q_ctrl         (q_ctrl),
      .q_value        (q_value),
      .q_x            (q_x),
      .q_y            (q_y),
      .adv            (adv),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_out_x      (rsp_out_x),
      .rsp_out_y      (rsp_out_y),
      .rsp_map_status (rsp_map_status)
   );

endmodule

[tb/sv/tb.sv]
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the projective point map: coefficient loads and
// point maps under random sender gaps and receiver stalls, checked in order
// against a bit-exact homography predictor
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
   import ppm_pkg::*;

   localparam int CB = 16;

   // one is 1.0 in the coefficient fixed point format
   localparam logic signed [COEF_W-1:0] ONE = 48'sd1 <<< 24;

   typedef struct {
      logic signed [CB-1:0] x;
      logic signed [CB-1:0] y;
      logic [STATUS_W-1:0]  status;
   } mapped_point_type;

   logic                         clock;
   logic                         reset;
   logic                         req_valid;
   logic                         req_stall;
   logic                         req_type;
   logic [INDEX_W-1:0]           req_coef_index;
   logic signed [COEF_W-1:0]     req_coef_value;
   logic signed [CB-1:0]         req_in_x;
   logic signed [CB-1:0]         req_in_y;
   logic                         rsp_valid;
   logic                         rsp_stall;
   logic signed [CB-1:0]         rsp_out_x;
   logic signed [CB-1:0]         rsp_out_y;
   logic [STATUS_W-1:0]          rsp_map_status;

   // predictor state: the matrix as the block should hold it
   logic signed [COEF_W-1:0] homography [NUM_COEFS];
   mapped_point_type         pending_points [$];
   int                       error_count = 0;
   int                       burst_left = 0;
   bit                       gaps_on = 1;

   projective_point_map #(.COORD_BITS(CB)) u_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_type       (req_type),
      .req_coef_index (req_coef_index),
      .req_coef_value (req_coef_value),
      .req_in_x       (req_in_x),
      .req_in_y       (req_in_y),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_out_x      (rsp_out_x),
      .rsp_out_y      (rsp_out_y),
      .rsp_map_status (rsp_map_status)
   );

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   // divide one row sum by w, round half away from zero, saturate
   function automatic void divide_round(input logic signed [129:0] num,
                                        input logic signed [129:0] den,
                                        output logic signed [CB-1:0] res,
                                        inout logic sat);
      logic [129:0] an, ad, q, lim;
      logic         neg;
      an  = num < 0 ? -num : num;
      ad  = den < 0 ? -den : den;
      neg = (num < 0) != (den < 0);
      q   = ((an << 1) + ad) / (ad << 1);
      // the negative side reaches one step further
      lim = neg ? 130'd32768 : 130'd32767;
      if (q > lim) begin
         sat = 1'b1;
         q   = lim;
      end
      res = neg ? CB'(-q) : CB'(q);
   endfunction

   // homogeneous product of the stored matrix with (x, y, 1)
   function automatic mapped_point_type project_point(logic signed [CB-1:0] x,
                                                      logic signed [CB-1:0] y);
      logic signed [129:0] px, py, sum [3];
      logic                sat;
      mapped_point_type    p;
      px = x;
      py = y;
      for (int r = 0; r < 3; r++) begin
         sum[r] = 130'(homography[3*r]) * px + 130'(homography[3*r+1]) * py
                  + 130'(homography[3*r+2]);
      end
      sat = 1'b0;
      p.x = '0;
      p.y = '0;
      if (sum[2] == 0) begin
         p.status = STATUS_ZERO;
      end else begin
         divide_round(sum[0], sum[2], p.x, sat);
         divide_round(sum[1], sum[2], p.y, sat);
         p.status = sat ? STATUS_SAT : STATUS_OK;
      end
      return p;
   endfunction

   // one transaction on the request channel; bursts with random gaps between when gaps_on is set
   task automatic send_item(ppm_kind_type kind, logic [INDEX_W-1:0] idx,
                            logic signed [COEF_W-1:0] value,
                            logic signed [CB-1:0] x, logic signed [CB-1:0] y);
      int  gap;
      bit  taken;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap        = gaps_on ? $urandom_range(1, 8) : 0;
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_valid      <= 1'b1;
      req_type       <= kind;
      req_coef_index <= idx;
      req_coef_value <= value;
      req_in_x       <= x;
      req_in_y       <= y;
      do begin
         @(negedge clock);
         taken = !req_stall;
         @(posedge clock);
      end while (!taken);
      // accepted at this edge: update the prediction in order
      if (kind == REQ_LOAD) begin
         if (idx < NUM_COEFS) homography[idx] = value;
      end else begin
         pending_points.push_back(project_point(x, y));
      end
   endtask

   task automatic load_coef(int idx, logic signed [COEF_W-1:0] value);
      send_item(REQ_LOAD, INDEX_W'(idx), value, CB'($urandom), CB'($urandom));
   endtask

   task automatic map_point(logic signed [CB-1:0] x, logic signed [CB-1:0] y);
      send_item(REQ_MAP, INDEX_W'($urandom), COEF_W'({$urandom, $urandom}), x, y);
   endtask

   task automatic load_matrix(logic signed [COEF_W-1:0] m [NUM_COEFS]);
      for (int i = 0; i < NUM_COEFS; i++) load_coef(i, m[i]);
   endtask

   // hold the sender until every expected point is back
   task automatic wait_drained();
      req_valid <= 1'b0;
      do begin
         @(posedge clock);
      end while (pending_points.size() != 0);
   endtask

   // random coefficient drawn from a few magnitude classes
   function automatic logic signed [COEF_W-1:0] random_coef();
      unique case ($urandom_range(0, 5))
         0:       return COEF_W'({$urandom, $urandom});
         1:       return '0;
         2:       return ONE + $signed(COEF_W'($urandom_range(0, 1 << 22))) - (1 << 21);
         3:       return $signed(COEF_W'($urandom_range(0, 1 << 12))) - (1 << 11);
         default: return $signed(COEF_W'($urandom_range(0, 1 << 27))) - (1 << 26);
      endcase
   endfunction

   // identity, extreme points and ignored out of range loads with extreme coefficients
   task automatic test_loads();
      logic signed [COEF_W-1:0] m [NUM_COEFS];
      m = '{ONE, 0, 0, 0, ONE, 0, 0, 0, ONE};
      load_matrix(m);
      // indexes above 8 are dropped and must not disturb the matrix
      load_coef(9, 48'sh7FFF_FFFF_FFFF);
      load_coef(15, 48'sh8000_0000_0000);
      map_point(16'sh7FFF, 16'sh8000);
      map_point(16'sh8000, 16'sh7FFF);
      map_point(0, 0);
   endtask

   // zero w, saturation both ways, half rounding, extreme coefficients
   task automatic test_special_points();
      logic signed [COEF_W-1:0] m [NUM_COEFS];
      // w = 0 everywhere
      m = '{ONE, 0, 0, 0, ONE, 0, 0, 0, 0};
      load_matrix(m);
      map_point(5, -7);
      // w = x: zero only at x = 0
      load_coef(6, ONE);
      map_point(0, 3);
      map_point(2, 3);
      map_point(-2, 3);
      // halves: scale by one half, odd inputs round away from zero
      m = '{ONE, 0, 0, 0, ONE, 0, 0, 0, ONE <<< 1};
      load_matrix(m);
      map_point(3, -3);
      map_point(-1, 1);
      // large gain saturates high and low
      load_coef(0, 48'sh7FFF_FFFF_FFFF);
      load_coef(4, 48'sh8000_0000_0000);
      map_point(16'sh7FFF, 16'sh7FFF);
      map_point(16'sh8000, 16'sh8000);
   endtask

   task automatic test_random_points();
      logic signed [COEF_W-1:0] m [NUM_COEFS];
      for (int i = 0; i < NUM_COEFS; i++) m[i] = random_coef();
      m[8] = ONE;
      load_matrix(m);
      for (int n = 0; n < 1750; n++) begin
         gaps_on = (n / 300) % 3 != 2;
         if (n == 900) wait_drained();
         if ($urandom_range(0, 15) == 0) begin
            load_coef($urandom_range(0, 15), random_coef());
         end else if ($urandom_range(0, 3) == 0) begin
            map_point(CB'($urandom), CB'($urandom));
         end else begin
            map_point(CB'(int'($urandom_range(0, 1023)) - 512),
                      CB'(int'($urandom_range(0, 1023)) - 512));
         end
      end
   endtask

   // receiver stall pattern: phases of none, light and heavy stalling
   int stall_cycle = 0;
   always @(posedge clock) begin
      stall_cycle <= stall_cycle + 1;
      unique case ((stall_cycle / 97) % 3)
         0:       rsp_stall <= 1'b0;
         1:       rsp_stall <= ($urandom_range(0, 3) == 0);
         default: rsp_stall <= ($urandom_range(0, 3) != 0);
      endcase
   end

   // compare every returned point with the oldest expected one
   always @(posedge clock) begin
      mapped_point_type e;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_points.size() == 0) begin
            $display("%0t unexpected point x=%0d y=%0d status=%0d", $time,
                     rsp_out_x, rsp_out_y, rsp_map_status);
            error_count++;
         end else begin
            e = pending_points.pop_front();
            if (rsp_out_x !== e.x) begin
               $display("%0t out_x expected %0d actual %0d", $time, e.x, rsp_out_x);
               error_count++;
            end
            if (rsp_out_y !== e.y) begin
               $display("%0t out_y expected %0d actual %0d", $time, e.y, rsp_out_y);
               error_count++;
            end
            if (rsp_map_status !== e.status) begin
               $display("%0t map_status expected %0d actual %0d", $time, e.status,
                        rsp_map_status);
               error_count++;
            end
         end
      end
   end

   initial begin
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_type       = REQ_LOAD;
      req_coef_index = '0;
      req_coef_value = '0;
      req_in_x       = '0;
      req_in_y       = '0;
      rsp_stall      = 1'b0;
      for (int i = 0; i < NUM_COEFS; i++) homography[i] = '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_loads();
      test_special_points();
      test_random_points();
      wait_drained();
      // make sure nothing extra trails out of the pipeline
      repeat (60) @(posedge clock);
      if (error_count == 0 && pending_points.size() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

   initial begin
      #20ms;
      $display("Regression FAIL");
      $finish;
   end

endmodule
